[hdl/wfl_pkg.sv]
// ----------------------------------------------------------------------------
// wfl_pkg: shared types and codes of the wall follower
// Request mode codes, register indexes and reset values, path cell type and scan chain flags.
// ----------------------------------------------------------------------------
package wfl_pkg;

   // request modes
   localparam logic [1:0] MODE_LOAD    = 2'd0;
   localparam logic [1:0] MODE_RESTART = 2'd1;
   localparam logic [1:0] MODE_ADVANCE = 2'd2;
   localparam logic [1:0] MODE_READ    = 2'd3;

   // configuration register indexes
   localparam logic [1:0] REG_START_X   = 2'd0;
   localparam logic [1:0] REG_START_Y   = 2'd1;
   localparam logic [1:0] REG_START_HDG = 2'd2;
   localparam logic [1:0] REG_SIDE      = 2'd3;

   // reset values of the registers
   localparam logic [4:0] RST_START_X   = 5'd18;
   localparam logic [4:0] RST_START_Y   = 5'd17;
   localparam logic [1:0] RST_START_HDG = 2'd3;
   localparam logic [5:0] RST_SIDE      = 6'd19;

   // a path cell: row in the upper five bits, column in the lower five
   typedef logic [9:0] cell_type;

   // flags travelling with one word along the scan chain
   typedef struct packed {
      logic valid;
      logic hit;
   } scan_flags_type;

endpackage

[hdl/wfl_scan_cell.sv]
// ----------------------------------------------------------------------------
// wfl_scan_cell: one cell of the path scan chain
// Holds one path word, compares it with the search key and hands it on.
// ----------------------------------------------------------------------------
module wfl_scan_cell #(
   parameter int IDX_W = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  wfl_pkg::cell_type       key,
   input  wfl_pkg::scan_flags_type in_flags,
   input  logic [IDX_W-1:0]        in_idx,
   input  wfl_pkg::cell_type       in_cell,
   output wfl_pkg::scan_flags_type out_flags,
   output logic [IDX_W-1:0]        out_idx,
   output wfl_pkg::cell_type       out_cell
);
   import wfl_pkg::*;

   scan_flags_type flags_ff, flags_in;
   logic [IDX_W-1:0] idx_ff;
   cell_type cell_ff;

   // match the incoming word against the key
   always_comb begin
      flags_in.valid = in_flags.valid;
      flags_in.hit   = in_flags.hit | (in_flags.valid & (in_cell == key));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      idx_ff  <= in_idx;
      cell_ff <= in_cell;
   end

   assign out_flags = flags_ff;
   assign out_idx   = idx_ff;
   assign out_cell  = cell_ff;

endmodule

[hdl/wall_follower_loop_erased_path.sv]
// Load and restart go straight to the status reads; a path read first reads the path store, a first
// move scans the path, an advance once finished does no look-up and one walled in does no scan.
// A later advance stops the scan at a repeat at path entry k, else pushes onto a path of n entries:
// the scan chain takes one path entry a cycle and the look-up reads three wall rows.
// One word at a time; a stalled response holds the next word back until it is taken.
// Reset: synchronous, active high; registers to defaults, walker to start cell, path empty.
// ----------------------------------------------------------------------------
// wall_follower_loop_erased_path: right-hand maze walker
// Wall bitmap memory, walker state, loop-erased path store with a scan chain.
// ----------------------------------------------------------------------------
module wall_follower_loop_erased_path #(
   parameter int MAX_SIDE   = 32,
   parameter int PATH_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [9:0]  req_row_or_index,
   input  logic [31:0] req_row_walls,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_pos_x,
   output logic [4:0]  rsp_pos_y,
   output logic [1:0]  rsp_heading,
   output logic        rsp_finished,
   output logic        rsp_stuck,
   output logic [10:0] rsp_path_length,
   output logic [4:0]  rsp_entry_x,
   output logic [4:0]  rsp_entry_y,
   output logic        rsp_entry_valid,
   output logic        rsp_overflow,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_wdata
);
   import wfl_pkg::*;

   localparam int RW        = $clog2(MAX_SIDE);
   localparam int AW        = $clog2(PATH_DEPTH);
   localparam int CNT_W     = $clog2(PATH_DEPTH + 1);
   localparam int CHAIN_LEN = 2;
   localparam int SIDE_CAP  = (MAX_SIDE < 32) ? MAX_SIDE : 32;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOOK  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_PUSH  = 3'd3;
   localparam logic [2:0] S_PREAD = 3'd4;
   localparam logic [2:0] S_STAT  = 3'd5;

   // configuration
   logic [4:0] sx_ff, sy_ff;
   logic [1:0] sh_ff;
   logic [5:0] side_ff;

   // walker and path state
   logic [2:0] state_ff, state_in;
   logic [1:0] rc_ff, rc_in;
   logic [4:0] x_ff, x_in, y_ff, y_in;
   logic [1:0] hdg_ff, hdg_in;
   logic first_ff, first_in;
   logic ovf_ff, ovf_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [31:0] up_ff, up_in, mid_ff, mid_in;
   logic [4:0] ent_x_ff, ent_x_in, ent_y_ff, ent_y_in;
   logic ent_v_ff, ent_v_in;

   // response register
   logic rsp_vld_ff, rsp_vld_in;
   logic [4:0] rx_ff, ry_ff, rex_ff, rey_ff;
   logic [1:0] rh_ff;
   logic rfin_ff, rstk_ff, rev_ff, rovf_ff;
   logic [10:0] rlen_ff;
   logic rsp_load;

   // memories and their ports
   logic [31:0] wall_mem [MAX_SIDE];
   logic [31:0] wall_q_ff;
   logic wall_oor_ff;
   logic wall_we, wall_re;
   logic [4:0] wall_row;
   cell_type path_mem [PATH_DEPTH];
   cell_type path_q_ff;
   logic path_we, path_re, tok_in;
   logic [AW-1:0] path_raddr;
   logic tok_vld_ff;
   logic [CNT_W-1:0] tok_idx_ff;

   // scan chain
   scan_flags_type   ch_flags [CHAIN_LEN+1];
   logic [CNT_W-1:0] ch_idx   [CHAIN_LEN+1];
   cell_type         ch_cell  [CHAIN_LEN+1];
   logic [CHAIN_LEN-1:0] ch_busy;

   logic accept;
   logic [31:0] down_row;
   logic [3:0] nb;
   logic in_maze, walled;
   logic [6:0] side_eff;
   logic [1:0] turn_hdg;
   logic drained;
   cell_type key;

   function automatic logic [4:0] step_x(input logic [4:0] x, input logic [1:0] h);
      logic [4:0] r;
      r = x;
      if (h == 2'd1) r = x + 5'd1;
      if (h == 2'd3) r = x - 5'd1;
      return r;
   endfunction

   function automatic logic [4:0] step_y(input logic [4:0] y, input logic [1:0] h);
      logic [4:0] r;
      r = y;
      if (h == 2'd0) r = y - 5'd1;
      if (h == 2'd2) r = y + 5'd1;
      return r;
   endfunction

   // right turn, then left while the cell ahead is wall
   function automatic logic [1:0] pick_hdg(input logic [1:0] h, input logic [3:0] w);
      logic [1:0] c;
      logic done;
      c    = h + 2'd1;
      done = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (!done) begin
            if (w[c]) c = c - 2'd1;
            else done = 1'b1;
         end
      end
      return c;
   endfunction

   assign accept    = req_valid & ~req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign key       = {y_ff, x_ff};

   // interior test on the clamped side
   always_comb begin
      side_eff = ({1'b0, side_ff} > 7'(SIDE_CAP)) ? 7'(SIDE_CAP) : {1'b0, side_ff};
      in_maze  = (x_ff != 5'd0) && ((7'(x_ff) + 7'd1) < side_eff) &&
                 (y_ff != 5'd0) && ((7'(y_ff) + 7'd1) < side_eff);
   end

   // neighbour walls from the three rows read
   always_comb begin
      down_row = wall_oor_ff ? '1 : wall_q_ff;
      nb[0]    = up_ff[x_ff];
      nb[1]    = mid_ff[x_ff + 5'd1];
      nb[2]    = down_row[x_ff];
      nb[3]    = mid_ff[x_ff - 5'd1];
      walled   = &nb;
      turn_hdg = pick_hdg(hdg_ff, nb);
   end

   // scan chain of identical cells behind the path memory read
   assign ch_flags[0] = '{valid: tok_vld_ff, hit: 1'b0};
   assign ch_idx[0]   = tok_idx_ff;
   assign ch_cell[0]  = path_q_ff;

   for (genvar g = 0; g < CHAIN_LEN; g++) begin : g_chain
      wfl_scan_cell #(.IDX_W(CNT_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .key       (key),
         .in_flags  (ch_flags[g]),
         .in_idx    (ch_idx[g]),
         .in_cell   (ch_cell[g]),
         .out_flags (ch_flags[g+1]),
         .out_idx   (ch_idx[g+1]),
         .out_cell  (ch_cell[g+1])
      );
      assign ch_busy[g] = ch_flags[g+1].valid;
   end

   assign drained = ~tok_vld_ff & ~(|ch_busy);

   // sequencer
   always_comb begin
      state_in = state_ff;
      rc_in    = rc_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      hdg_in   = hdg_ff;
      first_in = first_ff;
      ovf_in   = ovf_ff;
      cnt_in   = cnt_ff;
      ptr_in   = ptr_ff;
      up_in    = up_ff;
      mid_in   = mid_ff;
      ent_x_in = ent_x_ff;
      ent_y_in = ent_y_ff;
      ent_v_in = ent_v_ff;
      wall_we  = 1'b0;
      wall_re  = 1'b0;
      wall_row = 5'(y_ff + 5'(rc_ff) - 5'd1);
      path_we  = 1'b0;
      path_re  = 1'b0;
      tok_in   = 1'b0;
      path_raddr = AW'(ptr_ff);
      rsp_load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            rc_in = 2'd0;
            if (accept) begin
               ent_x_in = 5'd0;
               ent_y_in = 5'd0;
               ent_v_in = 1'b0;
               state_in = S_STAT;
               case (req_mode)
                  MODE_LOAD: begin
                     wall_we = (32'(req_row_or_index) < 32'(MAX_SIDE));
                  end
                  MODE_RESTART: begin
                     x_in     = sx_ff;
                     y_in     = sy_ff;
                     hdg_in   = sh_ff;
                     first_in = 1'b1;
                     cnt_in   = '0;
                     ovf_in   = 1'b0;
                  end
                  MODE_ADVANCE: begin
                     if (first_ff) begin
                        first_in = 1'b0;
                        x_in     = step_x(x_ff, hdg_ff);
                        y_in     = step_y(y_ff, hdg_ff);
                        ptr_in   = '0;
                        state_in = S_SCAN;
                     end else if (in_maze) begin
                        state_in = S_LOOK;
                     end
                  end
                  default: begin
                     if (32'(req_row_or_index) < 32'(cnt_ff)) begin
                        path_re    = 1'b1;
                        path_raddr = AW'(req_row_or_index);
                        state_in   = S_PREAD;
                     end
                  end
               endcase
            end
         end
         S_LOOK: begin
            // rows y-1, y, y+1 come back in the cycle after each read
            rc_in = rc_ff + 2'd1;
            if (rc_ff != 2'd3) wall_re = 1'b1;
            if (rc_ff == 2'd1) up_in  = down_row;
            if (rc_ff == 2'd2) mid_in = down_row;
            if (rc_ff == 2'd3) begin
               rc_in = 2'd0;
               if (walled) begin
                  state_in = S_STAT;
               end else begin
                  hdg_in   = turn_hdg;
                  x_in     = step_x(x_ff, turn_hdg);
                  y_in     = step_y(y_ff, turn_hdg);
                  ptr_in   = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // issue one path read a cycle, the chain reports the first match
            if (ptr_ff < cnt_ff) begin
               path_re = 1'b1;
               tok_in  = 1'b1;
               ptr_in  = ptr_ff + 1'b1;
            end
            if (ch_flags[CHAIN_LEN].valid && ch_flags[CHAIN_LEN].hit) begin
               cnt_in   = ch_idx[CHAIN_LEN] + 1'b1;
               state_in = S_STAT;
            end else if (ptr_ff >= cnt_ff && drained) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (32'(cnt_ff) < 32'(PATH_DEPTH)) begin
               path_we = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
            state_in = S_STAT;
         end
         S_PREAD: begin
            ent_x_in = path_q_ff[4:0];
            ent_y_in = path_q_ff[9:5];
            ent_v_in = 1'b1;
            state_in = S_STAT;
         end
         S_STAT: begin
            // neighbour rows for the stuck flag, then the response word
            if (rc_ff != 2'd3) begin
               wall_re = 1'b1;
               rc_in   = rc_ff + 2'd1;
            end
            if (rc_ff == 2'd1) up_in  = down_row;
            if (rc_ff == 2'd2) mid_in = down_row;
            if (rc_ff == 2'd3 && !(rsp_vld_ff && rsp_stall)) begin
               rsp_load = 1'b1;
               rc_in    = 2'd0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_vld_in = rsp_load | (rsp_vld_ff & rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rc_ff      <= 2'd0;
         x_ff       <= RST_START_X;
         y_ff       <= RST_START_Y;
         hdg_ff     <= RST_START_HDG;
         first_ff   <= 1'b1;
         ovf_ff     <= 1'b0;
         cnt_ff     <= '0;
         ptr_ff     <= '0;
         tok_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         sx_ff      <= RST_START_X;
         sy_ff      <= RST_START_Y;
         sh_ff      <= RST_START_HDG;
         side_ff    <= RST_SIDE;
      end else begin
         state_ff   <= state_in;
         rc_ff      <= rc_in;
         x_ff       <= x_in;
         y_ff       <= y_in;
         hdg_ff     <= hdg_in;
         first_ff   <= first_in;
         ovf_ff     <= ovf_in;
         cnt_ff     <= cnt_in;
         ptr_ff     <= ptr_in;
         tok_vld_ff <= tok_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_START_X:   sx_ff   <= csr_wdata[4:0];
               REG_START_Y:   sy_ff   <= csr_wdata[4:0];
               REG_START_HDG: sh_ff   <= csr_wdata[1:0];
               REG_SIDE:      side_ff <= csr_wdata;
               default:       side_ff <= side_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      up_ff      <= up_in;
      mid_ff     <= mid_in;
      ent_x_ff   <= ent_x_in;
      ent_y_ff   <= ent_y_in;
      ent_v_ff   <= ent_v_in;
      tok_idx_ff <= ptr_ff;
      if (rsp_load) begin
         rx_ff   <= x_ff;
         ry_ff   <= y_ff;
         rh_ff   <= hdg_ff;
         rfin_ff <= ~first_ff & ~in_maze;
         rstk_ff <= ~first_ff & in_maze & walled;
         rlen_ff <= 11'(cnt_ff);
         rex_ff  <= ent_x_ff;
         rey_ff  <= ent_y_ff;
         rev_ff  <= ent_v_ff;
         rovf_ff <= ovf_ff;
      end
   end

   // wall bitmap memory
   always_ff @(posedge clock) begin
      if (wall_we) wall_mem[RW'(req_row_or_index)] <= req_row_walls;
      if (wall_re) begin
         wall_q_ff   <= wall_mem[RW'(wall_row)];
         wall_oor_ff <= ~(7'(wall_row) < 7'(MAX_SIDE));
      end
   end

   // path store memory
   always_ff @(posedge clock) begin
      if (path_we) path_mem[AW'(cnt_ff)] <= key;
      if (path_re) path_q_ff <= path_mem[path_raddr];
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_pos_x       = rx_ff;
   assign rsp_pos_y       = ry_ff;
   assign rsp_heading     = rh_ff;
   assign rsp_finished    = rfin_ff;
   assign rsp_stuck       = rstk_ff;
   assign rsp_path_length = rlen_ff;
   assign rsp_entry_x     = rex_ff;
   assign rsp_entry_y     = rey_ff;
   assign rsp_entry_valid = rev_ff;
   assign rsp_overflow    = rovf_ff;

   // path count stays within the store
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= 32'(PATH_DEPTH))
      else $error("path count beyond store depth");

   // a restart empties the path and rearms the first move
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_RESTART) |=> (cnt_ff == '0 && first_ff && !ovf_ff))
      else $error("restart did not clear walker state");

   // the scan pointer never runs past the path count
   a_scan_ptr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (ptr_ff <= cnt_ff))
      else $error("scan pointer past path count");

   // heading only turns in the neighbour look-up or on a restart
   a_hdg_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LOOK && !(accept && req_mode == MODE_RESTART)) |=> $stable(hdg_ff))
      else $error("heading changed outside a turn");

endmodule
